// ===== rtl/tst_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the transpose search table unit.
// Depends on nothing; used by tst_ctrl, the top level and the testbench.
package tst_pkg;

    // Table geometry
    localparam int DEPTH  = 1024;
    localparam int AW     = $clog2(DEPTH);
    localparam int KEY_W  = 32;
    localparam int IDX_W  = 10;
    localparam int POS_W  = 10;
    localparam int CNT_W  = 11;
    localparam int KIND_W = 2;

    // Scan pointer must hold the limit (up to DEPTH) and any start index
    localparam int LIM_W  = AW + 1;
    localparam int SCAN_W = (LIM_W > IDX_W + 1) ? LIM_W : IDX_W + 1;

    // Register reset value of the entry count
    localparam logic [CNT_W-1:0] CNT_RESET = CNT_W'(1024);

    // Operation codes
    localparam logic [KIND_W-1:0] KIND_WRITE     = 2'd0;
    localparam logic [KIND_W-1:0] KIND_PLAIN     = 2'd1;
    localparam logic [KIND_W-1:0] KIND_TRANSPOSE = 2'd2;

    typedef struct packed {
        logic [KIND_W-1:0]       kind;
        logic [IDX_W-1:0]        index;
        logic signed [KEY_W-1:0] key;
    } t_in_item;

    typedef struct packed {
        logic             found;
        logic [POS_W-1:0] position;
    } t_out_item;

    // Table port request from the sequencer
    typedef struct packed {
        logic             we;
        logic [AW-1:0]    waddr;
        logic [KEY_W-1:0] wdata;
        logic [AW-1:0]    raddr;
    } t_ram_req;

endpackage

// ===== rtl/tst_ram.sv =====
`timescale 1ns / 1ps
// Generic single-port-write, single-port-read RAM with registered read data.
// Depends on nothing.
module tst_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write one word, read one word per cycle
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/tst_ctrl.sv =====
`timescale 1ns / 1ps
// Sequencer of the search table: write, linear scan with one shared compare,
// and the transposition swap. Depends on tst_pkg; drives tst_ram.
module tst_ctrl (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  tst_pkg::t_in_item          i_item,
    input  logic [tst_pkg::SCAN_W-1:0] i_limit,
    input  logic [tst_pkg::KEY_W-1:0]  i_rdata,
    output tst_pkg::t_ram_req          o_ram,
    output logic                       o_busy,
    output logic                       o_done,
    output tst_pkg::t_out_item         o_result
);

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_SCAN  = 5'b00010,
        ST_SW_RD = 5'b00100,
        ST_SW_HI = 5'b01000,
        ST_SW_LO = 5'b10000
    } t_state;

    t_state                       r_state, n_state;
    logic [tst_pkg::KEY_W-1:0]    r_key, n_key;
    logic                         r_transpose, n_transpose;
    logic [tst_pkg::SCAN_W-1:0]   r_addr, n_addr;
    logic                         r_rd_valid, n_rd_valid;
    logic [tst_pkg::AW-1:0]       r_rd_idx, n_rd_idx;
    logic [tst_pkg::AW-1:0]       r_hit_idx, n_hit_idx;
    logic                         r_done, n_done;
    logic                         r_found, n_found;
    logic [tst_pkg::POS_W-1:0]    r_pos, n_pos;

    logic                         issue;
    logic                         match;
    logic [tst_pkg::AW-1:0]       hit_prev;

    assign issue    = r_addr < i_limit;
    assign match    = r_rd_valid && (i_rdata == r_key);
    assign hit_prev = r_hit_idx - tst_pkg::AW'(1);

    // Next state, table requests and result
    always_comb begin
        n_state     = r_state;
        n_key       = r_key;
        n_transpose = r_transpose;
        n_addr      = r_addr;
        n_rd_valid  = r_rd_valid;
        n_rd_idx    = r_rd_idx;
        n_hit_idx   = r_hit_idx;
        n_done      = 1'b0;
        n_found     = r_found;
        n_pos       = r_pos;
        o_ram.we    = 1'b0;
        o_ram.waddr = r_hit_idx;
        o_ram.wdata = r_key;
        o_ram.raddr = r_addr[tst_pkg::AW-1:0];

        unique case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    n_key       = i_item.key;
                    n_transpose = (i_item.kind == tst_pkg::KIND_TRANSPOSE);
                    n_rd_valid  = 1'b0;
                    n_found     = 1'b0;
                    n_pos       = '0;
                    priority if (i_item.kind == tst_pkg::KIND_WRITE) begin
                        // Store the key and report at once
                        o_ram.we    = tst_pkg::SCAN_W'(i_item.index)
                                      < tst_pkg::SCAN_W'(tst_pkg::DEPTH);
                        o_ram.waddr = i_item.index[tst_pkg::AW-1:0];
                        o_ram.wdata = i_item.key;
                        n_done      = 1'b1;
                    end else if (i_item.kind == tst_pkg::KIND_PLAIN) begin
                        n_addr  = tst_pkg::SCAN_W'(i_item.index);
                        n_state = ST_SCAN;
                    end else if (i_item.kind == tst_pkg::KIND_TRANSPOSE) begin
                        n_addr  = '0;
                        n_state = ST_SCAN;
                    end else begin
                        // Unused code: empty result
                        n_done = 1'b1;
                    end
                end
            end
            ST_SCAN: begin
                // Compare the word read last cycle, issue the next read
                if (match) begin
                    n_found   = 1'b1;
                    n_pos     = tst_pkg::POS_W'(r_rd_idx);
                    n_hit_idx = r_rd_idx;
                    if (r_transpose && (r_rd_idx != '0)) begin
                        n_state = ST_SW_RD;
                    end else begin
                        n_done  = 1'b1;
                        n_state = ST_IDLE;
                    end
                end else if (!issue) begin
                    n_done  = 1'b1;
                    n_state = ST_IDLE;
                end else begin
                    n_addr     = r_addr + tst_pkg::SCAN_W'(1);
                    n_rd_valid = 1'b1;
                    n_rd_idx   = r_addr[tst_pkg::AW-1:0];
                end
            end
            ST_SW_RD: begin
                // Fetch the predecessor of the hit
                o_ram.raddr = hit_prev;
                n_state     = ST_SW_HI;
            end
            ST_SW_HI: begin
                // Move the predecessor up into the hit slot
                o_ram.we    = 1'b1;
                o_ram.waddr = r_hit_idx;
                o_ram.wdata = i_rdata;
                n_state     = ST_SW_LO;
            end
            ST_SW_LO: begin
                // Put the found key one slot toward the front
                o_ram.we    = 1'b1;
                o_ram.waddr = hit_prev;
                o_ram.wdata = r_key;
                n_done      = 1'b1;
                n_state     = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_done     <= 1'b0;
            r_rd_valid <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_done     <= n_done;
            r_rd_valid <= n_rd_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_key       <= n_key;
        r_transpose <= n_transpose;
        r_addr      <= n_addr;
        r_rd_idx    <= n_rd_idx;
        r_hit_idx   <= n_hit_idx;
        r_found     <= n_found;
        r_pos       <= n_pos;
    end

    assign o_busy            = (r_state != ST_IDLE);
    assign o_done            = r_done;
    assign o_result.found    = r_found;
    assign o_result.position = r_pos;

endmodule

// ===== rtl/transpose_search_table_unit.sv =====
`timescale 1ns / 1ps
// Top level of the transpose search table: entry-count register, key table
// and sequencer. Depends on tst_pkg, tst_ram and tst_ctrl.
//
// An item is taken when i_start is high and o_busy is low. Its one result
// appears on o_result for a single cycle with o_result_strobe high, and the
// receiver cannot stall it. A write never raises o_busy. A search reads
// one table entry per cycle through the table's single read port, and a
// transposition search that hits above entry 0 then swaps the hit with its
// predecessor. The entry count is written through the cfg channel while the
// block is idle; counts above the table depth scan the whole table.
module transpose_search_table_unit (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  tst_pkg::t_in_item         i_item,
    output logic                      o_busy,
    output logic                      o_result_strobe,
    output tst_pkg::t_out_item        o_result,
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic [tst_pkg::CNT_W-1:0] i_cfg_data
);

    logic [tst_pkg::CNT_W-1:0]  r_entries;
    logic [tst_pkg::SCAN_W-1:0] cnt_ext;
    logic [tst_pkg::SCAN_W-1:0] limit;
    tst_pkg::t_ram_req          ram_req;
    logic [tst_pkg::KEY_W-1:0]  rdata;
    logic                       busy;

    // Take a count beat only while idle
    assign o_cfg_ready = !busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entries <= tst_pkg::CNT_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_entries <= i_cfg_data;
        end
    end

    // Saturate the count at the table depth
    assign cnt_ext = tst_pkg::SCAN_W'(r_entries);
    assign limit   = (cnt_ext > tst_pkg::SCAN_W'(tst_pkg::DEPTH))
                     ? tst_pkg::SCAN_W'(tst_pkg::DEPTH) : cnt_ext;

    tst_ram #(
        .WIDTH (tst_pkg::KEY_W),
        .DEPTH (tst_pkg::DEPTH)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_req.we),
        .i_waddr (ram_req.waddr),
        .i_wdata (ram_req.wdata),
        .i_raddr (ram_req.raddr),
        .o_rdata (rdata)
    );

    tst_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (i_start),
        .i_item   (i_item),
        .i_limit  (limit),
        .i_rdata  (rdata),
        .o_ram    (ram_req),
        .o_busy   (busy),
        .o_done   (o_result_strobe),
        .o_result (o_result)
    );

    assign o_busy = busy;

endmodule

// ===== tb/tst_lookup_checker.sv =====
`timescale 1ns / 1ps
// Checker for transpose_search_table_unit: tracks key table and entry count,
// predicts each lookup result and compares it. Depends on tst_pkg.
module tst_lookup_checker
    import tst_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic             i_busy,
    input  t_in_item         i_item,
    input  logic             i_result_strobe,
    input  t_out_item        i_result,
    input  logic             i_cfg_valid,
    input  logic             i_cfg_ready,
    input  logic [CNT_W-1:0] i_cfg_data,
    output int               o_errors,
    output int               o_pending
);

    logic [KEY_W-1:0] table_keys [DEPTH];
    logic [CNT_W-1:0] entry_count = CNT_RESET;
    t_out_item        lookups_due [$];
    int               mismatches = 0;
    int               due_count = 0;

    assign o_errors  = mismatches;
    assign o_pending = due_count;

    // Apply one command beat to the table copy and return its result
    function automatic t_out_item predict_lookup(input t_in_item it);
        t_out_item        res;
        int               lim;
        int               e;
        logic [KEY_W-1:0] held;
        res = '0;
        lim = (entry_count > DEPTH) ? DEPTH : int'(entry_count);
        case (it.kind)
            KIND_WRITE: begin
                table_keys[it.index] = it.key;
            end
            KIND_PLAIN: begin
                for (e = int'(it.index); e < lim && !res.found; e++) begin
                    if (table_keys[e] == it.key) begin
                        res.found    = 1'b1;
                        res.position = e[POS_W-1:0];
                    end
                end
            end
            KIND_TRANSPOSE: begin
                for (e = 0; e < lim && !res.found; e++) begin
                    if (table_keys[e] == it.key) begin
                        res.found    = 1'b1;
                        res.position = e[POS_W-1:0];
                    end
                end
                // move the hit one entry toward the front
                if (res.found && res.position != 0) begin
                    held                          = table_keys[res.position];
                    table_keys[res.position]      = table_keys[res.position - 1];
                    table_keys[res.position - 1]  = held;
                end
            end
            default: ;
        endcase
        return res;
    endfunction

    task automatic flag_error(input string what);
        if (mismatches < 10)
            $display("%0t: %s", $realtime, what);
        mismatches++;
    endtask

    // Watch both channels; compare results before taking the new command
    always @(posedge i_clk) begin
        t_out_item want;
        if (!i_rst_n) begin
            lookups_due.delete();
            entry_count = CNT_RESET;
        end else begin
            if (i_cfg_valid && i_cfg_ready)
                entry_count = i_cfg_data;
            if (i_result_strobe) begin
                if (lookups_due.size() == 0) begin
                    flag_error($sformatf("unexpected result found=%0d position=%0d",
                                         i_result.found, i_result.position));
                end else begin
                    want = lookups_due.pop_front();
                    if (i_result.found !== want.found || i_result.position !== want.position)
                        flag_error($sformatf({"result mismatch: expected found=%0d ",
                                              "position=%0d, got found=%0d position=%0d"},
                                             want.found, want.position,
                                             i_result.found, i_result.position));
                end
            end
            if (i_start && !i_busy)
                lookups_due.push_back(predict_lookup(i_item));
        end
        due_count = lookups_due.size();
    end

endmodule

// ===== tb/tb_transpose_search_table_unit.sv =====
`timescale 1ns / 1ps
// Testbench top for transpose_search_table_unit: clock, reset, command and
// entry-count stimulus, watchdog and verdict. Depends on tst_pkg, the block
// and tst_lookup_checker.
module tb_transpose_search_table_unit;
    import tst_pkg::*;

    localparam int               STALL_LIMIT = 5000;
    localparam int               DRAIN_WAIT  = 1100;
    localparam int               NKEYS       = 12;
    localparam int               RECENT_MAX  = 32;
    localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

    logic             clk;
    logic             rst_n;
    logic             start;
    t_in_item         item;
    logic             busy;
    logic             strobe;
    t_out_item        result;
    logic             cfg_valid;
    logic             cfg_ready;
    logic [CNT_W-1:0] cfg_data;
    int               errors;
    int               pending;

    bit               written [DEPTH];
    int               filled = 0;
    logic [KEY_W-1:0] key_pool [NKEYS];
    logic [KEY_W-1:0] recent_keys [$];
    int               burst_left = 0;
    int               stall_cycles = 0;

    transpose_search_table_unit dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_start         (start),
        .i_item          (item),
        .o_busy          (busy),
        .o_result_strobe (strobe),
        .o_result        (result),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (cfg_ready),
        .i_cfg_data      (cfg_data)
    );

    tst_lookup_checker checker_i (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_start         (start),
        .i_busy          (busy),
        .i_item          (item),
        .i_result_strobe (strobe),
        .i_result        (result),
        .i_cfg_valid     (cfg_valid),
        .i_cfg_ready     (cfg_ready),
        .i_cfg_data      (cfg_data),
        .o_errors        (errors),
        .o_pending       (pending)
    );

    // 4 ns clock
    always begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    // End the run when no beat moves for too long
    always @(posedge clk) begin
        if ((start && !busy) || strobe || (cfg_valid && cfg_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // Pool keys give frequent hits, recent keys give deep hits
    function automatic logic [KEY_W-1:0] pick_key();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40)
            return key_pool[$urandom_range(0, NKEYS - 1)];
        if (r < 75 && recent_keys.size() > 0)
            return recent_keys[$urandom_range(0, recent_keys.size() - 1)];
        return $urandom();
    endfunction

    // Drive one command beat in bursts with random gaps; called at a falling edge
    task automatic send_item(input logic [KIND_W-1:0] kind, input int idx,
                             input logic [KEY_W-1:0] key);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
            repeat (gap) @(negedge clk);
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(1, 12);
        end
        item.kind  = kind;
        item.index = idx[IDX_W-1:0];
        item.key   = key;
        start      = 1'b1;
        do @(posedge clk); while (busy);
        @(negedge clk);
        start = 1'b0;
        burst_left--;
        // track written entries so no search reaches an unwritten one
        if (kind == KIND_WRITE) begin
            written[idx] = 1'b1;
            recent_keys.push_back(key);
            if (recent_keys.size() > RECENT_MAX)
                void'(recent_keys.pop_front());
            while (filled < DEPTH && written[filled])
                filled++;
        end
    endtask

    // Write the entry count once every result is back
    task automatic set_entry_count(input int count);
        while (pending != 0) @(negedge clk);
        cfg_data  = count[CNT_W-1:0];
        cfg_valid = 1'b1;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    // Write every entry below upto that searches may scan
    task automatic load_prefix(input int upto);
        while (filled < upto)
            send_item(KIND_WRITE, filled,
                      ($urandom_range(0, 9) < 6) ? $urandom()
                                                 : key_pool[$urandom_range(0, NKEYS - 1)]);
    endtask

    // One random phase under a given entry count
    task automatic run_phase(input int count, input int n);
        int lim;
        int r;
        int idx;
        set_entry_count(count);
        lim = (count > DEPTH) ? DEPTH : count;
        load_prefix(lim);
        repeat (n) begin
            r = $urandom_range(0, 99);
            if (r < 25) begin
                idx = $urandom_range(0, 1) ? $urandom_range(0, DEPTH - 1) : $urandom_range(0, lim);
                if (idx >= DEPTH)
                    idx = DEPTH - 1;
                send_item(KIND_WRITE, idx, pick_key());
            end else if (r < 55) begin
                send_item(KIND_TRANSPOSE, $urandom_range(0, DEPTH - 1), pick_key());
            end else if (r < 95) begin
                idx = (lim == 0 || $urandom_range(0, 4) == 0) ? $urandom_range(0, DEPTH - 1)
                                                             : $urandom_range(0, lim - 1);
                send_item(KIND_PLAIN, idx, pick_key());
            end else begin
                send_item(KIND_UNUSED, $urandom_range(0, DEPTH - 1), $urandom());
            end
        end
    endtask

    initial begin
        rst_n     = 1'b0;
        start     = 1'b0;
        item      = '0;
        cfg_valid = 1'b0;
        cfg_data  = '0;
        key_pool[0] = 32'h8000_0000;
        key_pool[1] = 32'h7FFF_FFFF;
        key_pool[2] = 32'h0000_0000;
        key_pool[3] = 32'hFFFF_FFFF;
        key_pool[4] = 32'h0000_0001;
        for (int k = 5; k < NKEYS; k++)
            key_pool[k] = $urandom();
        // Hold reset, then release it on a falling edge
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Empty scan range: every search misses without reading
        set_entry_count(0);
        send_item(KIND_WRITE, 0, 32'h8000_0000);
        send_item(KIND_WRITE, 1, 32'h7FFF_FFFF);
        send_item(KIND_WRITE, 2, 32'h0000_0000);
        send_item(KIND_WRITE, 3, 32'hFFFF_FFFF);
        send_item(KIND_WRITE, 4, 32'h0000_0001);
        send_item(KIND_WRITE, 5, 32'h5A5A_A5A5);
        send_item(KIND_WRITE, 6, 32'hFFFF_FFFF);
        send_item(KIND_WRITE, 7, 32'h1234_5678);
        send_item(KIND_WRITE, DEPTH - 1, 32'h0F0F_F0F0);
        send_item(KIND_PLAIN, 0, 32'h0000_0000);
        send_item(KIND_TRANSPOSE, 0, 32'h8000_0000);

        // Eight entries: front hit, swaps, start at and past the limit
        set_entry_count(8);
        send_item(KIND_TRANSPOSE, 0, 32'h8000_0000);
        send_item(KIND_TRANSPOSE, 0, 32'h5A5A_A5A5);
        send_item(KIND_TRANSPOSE, DEPTH - 1, 32'h5A5A_A5A5);
        send_item(KIND_PLAIN, 3, 32'hFFFF_FFFF);
        send_item(KIND_PLAIN, 4, 32'hFFFF_FFFF);
        send_item(KIND_PLAIN, 7, 32'h1234_5678);
        send_item(KIND_PLAIN, 8, 32'h1234_5678);
        send_item(KIND_PLAIN, DEPTH - 1, 32'h0000_0000);
        send_item(KIND_TRANSPOSE, 0, 32'h7777_0000);
        send_item(KIND_UNUSED, DEPTH - 1, 32'hFFFF_FFFF);
        send_item(KIND_TRANSPOSE, 0, 32'h1234_5678);

        // Random phases; large counts stay few since each search scans the table
        run_phase(1, 25);
        run_phase(2, 25);
        run_phase(5, 40);
        run_phase(16, 60);
        run_phase(40, 60);
        run_phase(0, 20);
        run_phase(12, 60);
        run_phase(64, 60);
        run_phase(30, 50);
        run_phase(200, 50);
        run_phase(1024, 40);
        run_phase(2047, 30);
        run_phase(1025, 20);
        run_phase(3, 40);

        // Drain, then make sure nothing extra shows up
        while (pending != 0) @(negedge clk);
        repeat (DRAIN_WAIT) @(negedge clk);
        if (errors == 0 && pending == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ===== transpose_search_table_unit.f =====
rtl/tst_pkg.sv
rtl/tst_ram.sv
rtl/tst_ctrl.sv
rtl/transpose_search_table_unit.sv
tb/tst_lookup_checker.sv
tb/tb_transpose_search_table_unit.sv
